// File: rtl/mh_pkg.sv
// Package for the magnetometer heading block: widths, register indexes,
// controller states, command word and the CORDIC arctangent table.
// No dependencies; compile first.
package mh_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int STEPS_EFF     = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS
                                                                   : ANG_TABLE_LEN;
    localparam int STEP_W        = $clog2(ANG_TABLE_LEN);

    localparam int SAMPLE_W  = 16;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int VEC_W     = PROD_W + 2;
    localparam int ANG_W     = 26;
    localparam int ATAN_W    = 22;
    localparam int HEAD_W    = 15;
    localparam int HSUM_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_OFFSET_X    = 3'd0;
    localparam cfg_index_t REG_OFFSET_Y    = 3'd1;
    localparam cfg_index_t REG_SCALE_X     = 3'd2;
    localparam cfg_index_t REG_SCALE_Y     = 3'd3;
    localparam cfg_index_t REG_DECLINATION = 3'd4;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_EFF - 1);

    // Angles in 2^-16 degree; headings in 1/64 degree
    localparam logic signed [ANG_W-1:0]  ANG_PLUS_90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0]  ANG_MINUS_90 = -ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0]  ANG_ROUND    = ANG_W'(512);
    localparam logic signed [HSUM_W-1:0] FULL_TURN    = HSUM_W'(23040);
    localparam logic signed [HEAD_W-1:0] DEC_MAX      = HEAD_W'(11520);
    localparam logic signed [HEAD_W-1:0] DEC_MIN      = -HEAD_W'(11520);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PRE,
        ST_ITER,
        ST_FIN
    } mh_state_t;

    typedef struct packed {
        logic              accept;
        logic              fail;
        logic              mul;
        logic              pre;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              fin;
    } mh_cmd_t;

    // round(atan(2^-i) * 2^16) in degrees
    function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] a;
        case (i)
            5'd0:    a = 22'd2949120;
            5'd1:    a = 22'd1740967;
            5'd2:    a = 22'd919879;
            5'd3:    a = 22'd466945;
            5'd4:    a = 22'd234379;
            5'd5:    a = 22'd117304;
            5'd6:    a = 22'd58666;
            5'd7:    a = 22'd29335;
            5'd8:    a = 22'd14668;
            5'd9:    a = 22'd7334;
            5'd10:   a = 22'd3667;
            5'd11:   a = 22'd1833;
            5'd12:   a = 22'd917;
            5'd13:   a = 22'd458;
            5'd14:   a = 22'd229;
            5'd15:   a = 22'd115;
            5'd16:   a = 22'd57;
            5'd17:   a = 22'd29;
            5'd18:   a = 22'd14;
            5'd19:   a = 22'd7;
            5'd20:   a = 22'd4;
            5'd21:   a = 22'd2;
            5'd22:   a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/mh_if.sv
// Handshake interfaces for the magnetometer heading block: sample words in,
// heading words out. Depends on mh_pkg.
interface mh_in_if;
    import mh_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mag_x;
    logic signed [SAMPLE_W-1:0] mag_y;
    logic                       read_ok;

    modport source (output valid, output mag_x, output mag_y, output read_ok,
                    input ready);
    modport sink   (input valid, input mag_x, input mag_y, input read_ok,
                    output ready);
endinterface

interface mh_out_if;
    import mh_pkg::*;

    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] heading;
    logic              fresh;

    modport source (output valid, output heading, output fresh, input ready);
    modport sink   (input valid, input heading, input fresh, output ready);
endinterface

// File: rtl/mh_ctrl.sv
// Controller for the magnetometer heading block: sequences scaling,
// CORDIC steps and result load; owns the output valid flag.
// Depends on mh_pkg.
module mh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            read_ok,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    output mh_pkg::mh_cmd_t cmd
);
    import mh_pkg::*;

    mh_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.fail   = !read_ok;
                    state_next = read_ok ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PRE;
            end
            ST_PRE:
            begin
                cmd.pre    = 1'b1;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter = 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_FIN;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FIN:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken word");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (step_reg <= LAST_STEP))
        else $error("CORDIC step index out of range");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER && step_reg == LAST_STEP) |=> (state_reg == ST_FIN))
        else $error("iteration did not end after the last step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg != ST_IDLE && !in_ready))
        else $error("ready again right after accepting a word");

endmodule

// File: rtl/mh_datapath.sv
// Datapath for the magnetometer heading block: config registers, scaling
// multiply, shared CORDIC step, heading wrap and result registers.
// Depends on mh_pkg.
module mh_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  mh_pkg::cfg_index_t                 cfg_index,
    input  logic [mh_pkg::CFG_W-1:0]           cfg_wdata,
    input  mh_pkg::mh_cmd_t                    cmd,
    input  logic signed [mh_pkg::SAMPLE_W-1:0] mag_x,
    input  logic signed [mh_pkg::SAMPLE_W-1:0] mag_y,
    output logic [mh_pkg::HEAD_W-1:0]          heading,
    output logic                               fresh
);
    import mh_pkg::*;

    logic signed [SAMPLE_W-1:0] offset_x_reg, offset_y_reg;
    logic        [SAMPLE_W-1:0] scale_x_reg, scale_y_reg;
    logic signed [HEAD_W-1:0]   declination_reg;
    logic [HEAD_W-1:0]          last_heading_reg;
    logic                       has_heading_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [VEC_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic                     zero_reg;
    logic                     held_reg;
    logic [HEAD_W-1:0]        heading_reg;
    logic                     fresh_reg;

    logic signed [PROD_W-1:0]  prod_x, prod_y;
    logic signed [VEC_W-1:0]   sh_x, sh_y;
    logic signed [ANG_W-1:0]   atan_ang;
    logic signed [ANG_W-1:0]   ang, ang_rnd;
    logic signed [HEAD_W-1:0]  dec_sat;
    logic signed [HSUM_W-1:0]  h_sum, h_wrap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            scale_x_reg     <= SAMPLE_W'(4096);
            scale_y_reg     <= SAMPLE_W'(4096);
            declination_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X:    offset_x_reg    <= cfg_wdata;
                REG_OFFSET_Y:    offset_y_reg    <= cfg_wdata;
                REG_SCALE_X:     scale_x_reg     <= cfg_wdata;
                REG_SCALE_Y:     scale_y_reg     <= cfg_wdata;
                REG_DECLINATION: declination_reg <= cfg_wdata[HEAD_W-1:0];
                default:         ;
            endcase
        end
    end

    assign prod_x   = dx_reg * $signed({1'b0, scale_x_reg});
    assign prod_y   = dy_reg * $signed({1'b0, scale_y_reg});
    assign sh_x     = x_reg >>> cmd.step;
    assign sh_y     = y_reg >>> cmd.step;
    assign atan_ang = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_step(cmd.step)});

    // heading from the final angle
    always_comb
    begin
        ang     = zero_reg ? '0 : z_reg;
        ang_rnd = ang + ANG_ROUND;
        if (declination_reg > DEC_MAX)
            dec_sat = DEC_MAX;
        else if (declination_reg < DEC_MIN)
            dec_sat = DEC_MIN;
        else
            dec_sat = declination_reg;
        h_sum = $signed({ang_rnd[ANG_W-1], ang_rnd[ANG_W-1:10]})
              + $signed({{(HSUM_W-HEAD_W){dec_sat[HEAD_W-1]}}, dec_sat});
        h_wrap = h_sum;
        if (h_sum < 0)
            h_wrap = h_sum + FULL_TURN;
        else if (h_sum >= FULL_TURN)
            h_wrap = h_sum - FULL_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dx_reg   <= $signed({mag_x[SAMPLE_W-1], mag_x})
                      - $signed({offset_x_reg[SAMPLE_W-1], offset_x_reg});
            dy_reg   <= $signed({mag_y[SAMPLE_W-1], mag_y})
                      - $signed({offset_y_reg[SAMPLE_W-1], offset_y_reg});
            held_reg <= cmd.fail;
        end
        if (cmd.mul)
        begin
            x_reg <= VEC_W'(prod_x);
            y_reg <= VEC_W'(prod_y);
        end
        if (cmd.pre)
        begin
            zero_reg <= (x_reg == '0) && (y_reg == '0);
            // rotate left-half-plane vectors by a quarter turn
            if (x_reg < 0)
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= y_reg;
                    y_reg <= -x_reg;
                    z_reg <= ANG_PLUS_90;
                end
                else
                begin
                    x_reg <= -y_reg;
                    y_reg <= x_reg;
                    z_reg <= ANG_MINUS_90;
                end
            end
            else
                z_reg <= '0;
        end
        if (cmd.iter)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + sh_y;
                y_reg <= y_reg - sh_x;
                z_reg <= z_reg + atan_ang;
            end
            else
            begin
                x_reg <= x_reg - sh_y;
                y_reg <= y_reg + sh_x;
                z_reg <= z_reg - atan_ang;
            end
        end
        if (cmd.fin)
        begin
            if (held_reg)
            begin
                heading_reg <= has_heading_reg ? last_heading_reg : '0;
                fresh_reg   <= 1'b0;
            end
            else
            begin
                heading_reg <= h_wrap[HEAD_W-1:0];
                fresh_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_heading_reg <= '0;
            has_heading_reg  <= 1'b0;
        end
        else if (cmd.fin && !held_reg)
        begin
            last_heading_reg <= h_wrap[HEAD_W-1:0];
            has_heading_reg  <= 1'b1;
        end
    end

    assign heading = heading_reg;
    assign fresh   = fresh_reg;

endmodule

// File: rtl/magnetometer_heading.sv
// Top level of the magnetometer compass heading block: joins controller
// and datapath. Depends on mh_pkg, mh_if, mh_ctrl and mh_datapath.
//
//   channel      dir  handshake      payload
//   sample_in    in   valid/ready    mag_x[16] s, mag_y[16] s, read_ok
//   heading_out  out  valid/ready    heading[15] (1/64 deg), fresh
//   cfg          in   cfg_we         cfg_index[3], cfg_wdata[16]
//
// A good sample runs through these steps from its accept to the earliest next accept:
// accept, a multiply step, a quarter-turn pre-rotation step,
// CORDIC_STEPS (16) passes through the single shared CORDIC step, and a
// wrap/load step. A failed read skips straight to the load step.
// The result sits in an output register; the next sample is accepted while
// it waits, and only the load cycle stalls if the old word is still untaken.
// Reset clears config to defaults and forgets the last heading.
module magnetometer_heading (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  mh_pkg::cfg_index_t         cfg_index,
    input  logic [mh_pkg::CFG_W-1:0]   cfg_wdata,
    mh_in_if.sink                      sample_in,
    mh_out_if.source                   heading_out
);
    import mh_pkg::*;

    mh_cmd_t cmd;

    // sequence one word at a time
    mh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .read_ok   (sample_in.read_ok),
        .in_ready  (sample_in.ready),
        .out_ready (heading_out.ready),
        .out_valid (heading_out.valid),
        .cmd       (cmd)
    );

    // scale, rotate, accumulate angle, wrap
    mh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .mag_x     (sample_in.mag_x),
        .mag_y     (sample_in.mag_y),
        .heading   (heading_out.heading),
        .fresh     (heading_out.fresh)
    );

endmodule
